/* design/distance_weighted_class_vote_assert.svh */
// assertion macros for the class vote block
`ifndef DISTANCE_WEIGHTED_CLASS_VOTE_ASSERT_SVH
`define DISTANCE_WEIGHTED_CLASS_VOTE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DWCV_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define DWCV_ASSERT(lbl, prop, msg) \
  `DWCV_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define DWCV_ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define DWCV_ASSERT(lbl, prop, msg)

`endif

`endif

/* design/dwcv_pkg.sv */
package dwcv_pkg;

  localparam int unsigned MAX_SAMPLES      = 1024;
  localparam int unsigned WEIGHT_FRAC_BITS = 16;

  // feature format is signed Q16.16
  localparam int unsigned FEAT_W    = 32;
  localparam int unsigned FEAT_FRAC = 16;
  localparam int unsigned NUM_FEAT  = 3;

  // 1 + sum of three 33-bit magnitudes fits here
  localparam int unsigned DIST_W = FEAT_W + 2;
  localparam int unsigned DIFF_W = FEAT_W + 1;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned Q_W    = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned SUM_W  = $clog2(MAX_SAMPLES) + WEIGHT_FRAC_BITS + 1;
  localparam int unsigned PROD_W = SUM_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(Q_W);

  localparam logic [DIST_W-1:0] ONE_FIX  = DIST_W'(1) << FEAT_FRAC;
  // partial remainder after the leading bits of 2^(frac+16) are taken in
  localparam logic [DIST_W-1:0] REM_INIT = DIST_W'(1) << (FEAT_FRAC - 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = FEAT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEST_A = 2'd0,
    CFG_TEST_B = 2'd1,
    CFG_TEST_C = 2'd2
  } cfg_idx_e;

endpackage

/* design/distance_weighted_class_vote.sv */
// Inverse-distance weighted two-class vote. Each training sample beat is
// taken in from idle, then the L1 distance is formed through a shared
// subtractor and an accumulating add/subtract, then a restoring divider
// makes one weight bit a cycle, then the weight is added to the class
// sum. A beat marked last then goes through two uses of one shared
// multiplier (sum times count per class) and a compare that loads the
// result register. A result waiting on out_stall_i holds off input only
// once the next decision is ready to load. Samples past MAX_SAMPLES are
// dropped and flagged. Test point registers are to be written through
// cfg_* only while the block is idle; the block itself does not enforce this.
module distance_weighted_class_vote
  import dwcv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [FEAT_W-1:0] feature_a_i,
  input  logic signed [FEAT_W-1:0] feature_b_i,
  input  logic signed [FEAT_W-1:0] feature_c_i,
  input  logic                     label_i,
  input  logic                     last_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     prediction_o,
  output logic [CNT_W-1:0]         sample_count_o,
  output logic                     overflow_o
);

`include "distance_weighted_class_vote_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIV,
    ST_ACC,
    ST_MUL_R,
    ST_MUL_F,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [STEP_W-1:0]   step_q;

  logic [FEAT_W-1:0]   test_a_q, test_b_q, test_c_q;
  logic [FEAT_W-1:0]   feat_a_q, feat_b_q, feat_c_q;
  logic                label_q, last_q;

  logic [DIFF_W-1:0]   diff_q;
  logic [DIST_W-1:0]   dist_q;
  logic [DIST_W-1:0]   rem_q;
  logic [Q_W-1:0]      quot_q;

  logic [SUM_W-1:0]    rise_sum_q, fall_sum_q;
  logic [CNT_W-1:0]    rise_cnt_q, fall_cnt_q;
  logic                dropped_q;

  logic [PROD_W-1:0]   prod_r_q, prod_f_q;

  logic                out_valid_q, pred_q, ovf_q;
  logic [CNT_W-1:0]    count_q;

  logic [FEAT_W-1:0]   feat_sel, test_sel;
  logic [DIFF_W-1:0]   diff_d;
  logic [DIST_W-1:0]   diff_ext;
  logic [DIST_W:0]     rem_shift;
  logic                quot_bit;
  logic [DIST_W-1:0]   rem_d;
  logic [CNT_W-1:0]    total;
  logic [SUM_W-1:0]    mul_a;
  logic [CNT_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                out_free;

  // feature and test coordinate for the current distance step
  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin
        feat_sel = feat_a_q;
        test_sel = test_a_q;
      end
      2'd1: begin
        feat_sel = feat_b_q;
        test_sel = test_b_q;
      end
      default: begin
        feat_sel = feat_c_q;
        test_sel = test_c_q;
      end
    endcase
  end

  assign diff_d   = {feat_sel[FEAT_W-1], feat_sel} - {test_sel[FEAT_W-1], test_sel};
  assign diff_ext = {diff_q[DIFF_W-1], diff_q};

  // restoring divide step, divisor is 1.0 + distance
  assign rem_shift = {rem_q, 1'b0};
  assign quot_bit  = rem_shift >= {1'b0, dist_q};
  assign rem_d     = quot_bit ? DIST_W'(rem_shift - {1'b0, dist_q}) : DIST_W'(rem_shift);

  assign total = rise_cnt_q + fall_cnt_q;

  // shared multiplier for the two class products
  assign mul_a = (state_q == ST_MUL_F) ? fall_sum_q : rise_sum_q;
  assign mul_b = (state_q == ST_MUL_F) ? fall_cnt_q : rise_cnt_q;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      test_a_q    <= '0;
      test_b_q    <= '0;
      test_c_q    <= '0;
      feat_a_q    <= '0;
      feat_b_q    <= '0;
      feat_c_q    <= '0;
      label_q     <= 1'b0;
      last_q      <= 1'b0;
      diff_q      <= '0;
      dist_q      <= '0;
      rem_q       <= '0;
      quot_q      <= '0;
      rise_sum_q  <= '0;
      fall_sum_q  <= '0;
      rise_cnt_q  <= '0;
      fall_cnt_q  <= '0;
      dropped_q   <= 1'b0;
      prod_r_q    <= '0;
      prod_f_q    <= '0;
      out_valid_q <= 1'b0;
      pred_q      <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TEST_A: test_a_q <= cfg_data_i;
          CFG_TEST_B: test_b_q <= cfg_data_i;
          CFG_TEST_C: test_c_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            feat_a_q <= feature_a_i;
            feat_b_q <= feature_b_i;
            feat_c_q <= feature_c_i;
            label_q  <= label_i;
            last_q   <= last_i;
            if (total >= CNT_W'(MAX_SAMPLES)) begin
              dropped_q <= 1'b1;
              state_q   <= last_i ? ST_MUL_R : ST_IDLE;
            end else begin
              dist_q  <= ONE_FIX;
              rem_q   <= REM_INIT;
              step_q  <= '0;
              state_q <= ST_DIST;
            end
          end
        end

        ST_DIST: begin
          // difference of step n is formed while step n-1 is folded in as |d|
          if (step_q < STEP_W'(NUM_FEAT)) begin
            diff_q <= diff_d;
          end
          if (step_q != '0) begin
            dist_q <= diff_q[DIFF_W-1] ? dist_q - diff_ext : dist_q + diff_ext;
          end
          if (step_q == STEP_W'(NUM_FEAT)) begin
            step_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end

        ST_DIV: begin
          rem_q  <= rem_d;
          quot_q <= {quot_q[Q_W-2:0], quot_bit};
          if (step_q == STEP_W'(Q_W - 1)) begin
            step_q  <= '0;
            state_q <= ST_ACC;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end

        ST_ACC: begin
          if (label_q) begin
            rise_sum_q <= rise_sum_q + SUM_W'(quot_q);
            rise_cnt_q <= rise_cnt_q + CNT_W'(1);
          end else begin
            fall_sum_q <= fall_sum_q + SUM_W'(quot_q);
            fall_cnt_q <= fall_cnt_q + CNT_W'(1);
          end
          state_q <= last_q ? ST_MUL_R : ST_IDLE;
        end

        ST_MUL_R: begin
          prod_r_q <= mul_p;
          state_q  <= ST_MUL_F;
        end

        ST_MUL_F: begin
          prod_f_q <= mul_p;
          state_q  <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pred_q      <= prod_r_q > prod_f_q;
            count_q     <= total;
            ovf_q       <= dropped_q;
            rise_sum_q  <= '0;
            fall_sum_q  <= '0;
            rise_cnt_q  <= '0;
            fall_cnt_q  <= '0;
            dropped_q   <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign prediction_o   = pred_q;
  assign sample_count_o = count_q;
  assign overflow_o     = ovf_q;

  `DWCV_ASSERT(a_count_bound, total <= CNT_W'(MAX_SAMPLES), "class counts exceed sample bound")
  `DWCV_ASSERT(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < dist_q), "divider remainder not below divisor")
  `DWCV_ASSERT(a_result_from_emit, $rose(out_valid_o) |-> $past(state_q == ST_EMIT), "result beat appeared outside decision")
  `DWCV_ASSERT(a_accept_starts_dist, (in_valid_i && !in_stall_o && total < CNT_W'(MAX_SAMPLES)) |=> (state_q == ST_DIST), "accepted sample did not start distance")

endmodule

/* tb/testbench.sv */
module testbench
  import dwcv_pkg::*;
;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 800;
  localparam int PHASE_ITEMS   = 70;
  localparam int N_DIR         = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam logic RISE = 1'b1;
  localparam logic FALL = 1'b0;

  localparam logic [FEAT_W-1:0] F_MAX  = 32'h7FFF_FFFF;
  localparam logic [FEAT_W-1:0] F_MIN  = 32'h8000_0000;
  localparam logic [FEAT_W-1:0] F_ZERO = 32'h0000_0000;
  localparam logic [FEAT_W-1:0] F_ONE  = 32'h0001_0000;

  typedef enum {PH_DIRECTED, PH_RECV_SLOW, PH_SEND_SLOW, PH_FULL_RATE} phase_e;

  typedef struct packed {
    logic             pred;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
  } vote_t;

  localparam vote_t NO_VOTE = '0;

  // cfg rows carry the register value in fa
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [FEAT_W-1:0]    fa;
    logic [FEAT_W-1:0]    fb;
    logic [FEAT_W-1:0]    fc;
    logic                 lbl;
    logic                 lst;
    logic                 typed;
    vote_t                want;
  } dir_row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic signed [FEAT_W-1:0] feature_a_i = '0;
  logic signed [FEAT_W-1:0] feature_b_i = '0;
  logic signed [FEAT_W-1:0] feature_c_i = '0;
  logic                     label_i     = 1'b0;
  logic                     last_i      = 1'b0;
  logic                     out_stall_i = 1'b0;
  logic                     in_stall_o;
  logic                     out_valid_o;
  logic                     prediction_o;
  logic [CNT_W-1:0]         sample_count_o;
  logic                     overflow_o;

  // predictor state
  logic [FEAT_W-1:0] tp_a = '0, tp_b = '0, tp_c = '0;
  longint unsigned   rise_wsum, fall_wsum;
  int unsigned       n_rise, n_fall;
  bit                dropped;

  vote_t  vote_q [$];
  vote_t  mon_want;
  phase_e phase      = PH_DIRECTED;
  phase_e seen_phase = PH_DIRECTED;
  int     send_idle_pct  = 12;
  int     recv_stall_pct = 40;
  int     hold_left      = 0;
  int     err_cnt        = 0;
  int     n_samples      = 0;
  int     n_votes        = 0;
  int     n_bound_sets   = 0;
  int     n_points       = 0;
  int     cycles         = 0;

  dir_row_t dir_tbl [N_DIR] = '{
    // at the test point after reset: lone rise, lone fall, then a tie
    '{1'b0, CFG_UNUSED_IDX, F_ZERO, F_ZERO, F_ZERO, RISE, 1'b1, 1'b1,
      '{RISE, CNT_W'(1), 1'b0}},
    '{1'b0, CFG_UNUSED_IDX, F_ZERO, F_ZERO, F_ZERO, FALL, 1'b1, 1'b1,
      '{FALL, CNT_W'(1), 1'b0}},
    '{1'b0, CFG_UNUSED_IDX, F_ZERO, F_ZERO, F_ZERO, RISE, 1'b0, 1'b0, NO_VOTE},
    '{1'b0, CFG_UNUSED_IDX, F_ZERO, F_ZERO, F_ZERO, FALL, 1'b1, 1'b1,
      '{FALL, CNT_W'(2), 1'b0}},
    // far corners round the weight down to zero
    '{1'b0, CFG_UNUSED_IDX, F_MIN, F_MIN, F_MIN, RISE, 1'b1, 1'b1,
      '{FALL, CNT_W'(1), 1'b0}},
    '{1'b0, CFG_UNUSED_IDX, F_MAX, F_MAX, F_MAX, RISE, 1'b1, 1'b1,
      '{FALL, CNT_W'(1), 1'b0}},
    '{1'b0, CFG_UNUSED_IDX, F_ONE, F_ZERO, F_ZERO, RISE, 1'b0, 1'b0, NO_VOTE},
    '{1'b0, CFG_UNUSED_IDX, F_ZERO, F_ZERO, F_ZERO, FALL, 1'b0, 1'b0, NO_VOTE},
    '{1'b0, CFG_UNUSED_IDX, F_ONE, F_ONE, F_ZERO, RISE, 1'b1, 1'b0, NO_VOTE},
    '{1'b1, CFG_TEST_A, F_MAX, F_ZERO, F_ZERO, FALL, 1'b0, 1'b0, NO_VOTE},
    '{1'b1, CFG_TEST_B, F_MIN, F_ZERO, F_ZERO, FALL, 1'b0, 1'b0, NO_VOTE},
    '{1'b1, CFG_TEST_C, F_MAX, F_ZERO, F_ZERO, FALL, 1'b0, 1'b0, NO_VOTE},
    '{1'b1, CFG_UNUSED_IDX, F_ZERO, F_ZERO, F_ZERO, FALL, 1'b0, 1'b0, NO_VOTE},
    // widest possible distance against a sample sitting on the point
    '{1'b0, CFG_UNUSED_IDX, F_MAX, F_MIN, F_MAX, FALL, 1'b0, 1'b0, NO_VOTE},
    '{1'b0, CFG_UNUSED_IDX, F_MIN, F_MAX, F_MIN, RISE, 1'b1, 1'b1,
      '{FALL, CNT_W'(2), 1'b0}},
    '{1'b0, CFG_UNUSED_IDX, F_MAX, F_MIN, F_MAX, RISE, 1'b1, 1'b1,
      '{RISE, CNT_W'(1), 1'b0}},
    '{1'b0, CFG_UNUSED_IDX, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFE_0000,
      FALL, 1'b0, 1'b0, NO_VOTE},
    '{1'b0, CFG_UNUSED_IDX, 32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_FFF0,
      RISE, 1'b0, 1'b0, NO_VOTE},
    '{1'b0, CFG_UNUSED_IDX, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001,
      RISE, 1'b1, 1'b0, NO_VOTE}
  };

  distance_weighted_class_vote i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .feature_a_i    (feature_a_i),
    .feature_b_i    (feature_b_i),
    .feature_c_i    (feature_c_i),
    .label_i        (label_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .prediction_o   (prediction_o),
    .sample_count_o (sample_count_o),
    .overflow_o     (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d votes outstanding", $time, vote_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint unsigned feat_dist(input logic [FEAT_W-1:0] x, t);
    longint diff;
    diff = longint'($signed(x)) - longint'($signed(t));
    return (diff < 0) ? longint'(-diff) : diff;
  endfunction

  // 1/(1+d) rounded down, with WEIGHT_FRAC_BITS fraction bits
  function automatic longint unsigned idw_weight(input logic [FEAT_W-1:0] fa, fb, fc);
    longint unsigned l1_len;
    l1_len = feat_dist(fa, tp_a) + feat_dist(fb, tp_b) + feat_dist(fc, tp_c);
    return (64'd1 << (WEIGHT_FRAC_BITS + FEAT_FRAC)) / ((64'd1 << FEAT_FRAC) + l1_len);
  endfunction

  function automatic bit vote_step(input logic [FEAT_W-1:0] fa, fb, fc,
                                   input logic lbl, lst, output vote_t res);
    longint unsigned w, rise_p, fall_p;
    res = NO_VOTE;
    if (n_rise + n_fall >= MAX_SAMPLES) begin
      dropped = 1'b1;
    end else begin
      w = idw_weight(fa, fb, fc);
      if (lbl) begin
        rise_wsum += w;
        n_rise++;
      end else begin
        fall_wsum += w;
        n_fall++;
      end
    end
    if (!lst) return 1'b0;
    // division by the total cancels, compare the scaled sums only
    rise_p   = rise_wsum * n_rise;
    fall_p   = fall_wsum * n_fall;
    res.pred = rise_p > fall_p;
    res.cnt  = CNT_W'(n_rise + n_fall);
    res.ovf  = dropped;
    rise_wsum = 0;
    fall_wsum = 0;
    n_rise    = 0;
    n_fall    = 0;
    dropped   = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [FEAT_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return F_MAX;
      1: return F_MIN;
      2: return F_ZERO;
      default: return '1;
    endcase
  endfunction

  // mostly near the test point so the weights spread out
  function automatic logic [FEAT_W-1:0] rand_feat(input logic [FEAT_W-1:0] t);
    logic [FEAT_W-1:0] off;
    int                sh;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return pick_extreme();
      default: begin
        sh  = $urandom_range(2, 24);
        off = $urandom & ((32'd1 << sh) - 1);
        return $urandom_range(0, 1) ? t + off : t - off;
      end
    endcase
  endfunction

  task automatic check_field(input string what, input int unsigned want, got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  task automatic push_sample(input logic [FEAT_W-1:0] fa, fb, fc, input logic lbl, lst,
                             input bit use_typed, input vote_t typed);
    vote_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    feature_a_i <= fa;
    feature_b_i <= fb;
    feature_c_i <= fc;
    label_i     <= lbl;
    last_i      <= lst;
    do @(posedge clk_i); while (in_stall_o);
    n_samples++;
    if (vote_step(fa, fb, fc, lbl, lst, res)) begin
      vote_q.insert(vote_q.size(), use_typed ? typed : res);
    end
  endtask

  task automatic drain_votes();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (vote_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TEST_A: tp_a = data;
      CFG_TEST_B: tp_b = data;
      CFG_TEST_C: tp_c = data;
      default: ;
    endcase
  endtask

  task automatic set_point(input logic [FEAT_W-1:0] a, b, c);
    cfg_write(CFG_TEST_A, a);
    cfg_write(CFG_TEST_B, b);
    cfg_write(CFG_TEST_C, c);
    cfg_write(CFG_UNUSED_IDX, $urandom);
    n_points++;
  endtask

  task automatic run_set(input int n);
    int bias;
    bias = $urandom_range(0, 100);
    for (int i = 0; i < n; i++) begin
      push_sample(rand_feat(tp_a), rand_feat(tp_b), rand_feat(tp_c),
                  $urandom_range(0, 99) < bias, i == n - 1, 1'b0, NO_VOTE);
    end
  endtask

  task automatic run_phase(input phase_e ph, input int send_pct, recv_pct);
    int done;
    int n;
    drain_votes();
    phase          = ph;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    case (ph)
      PH_RECV_SLOW: begin
        // small point around the origin, sign extended 20 bit values
        set_point(32'($signed($urandom_range(0, 20'hF_FFFF) - 20'h8_0000)),
                  32'($signed($urandom_range(0, 20'hF_FFFF) - 20'h8_0000)),
                  32'($signed($urandom_range(0, 20'hF_FFFF) - 20'h8_0000)));
      end
      PH_SEND_SLOW: set_point(pick_extreme(), pick_extreme(), pick_extreme());
      default: set_point($urandom, $urandom, $urandom);
    endcase
    done = 0;
    while (done < PHASE_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      run_set(n);
      done += n;
    end
  endtask

  // receiver: random stall, plus one long hold-off when full rate starts
  always @(negedge clk_i) begin
    if (phase != seen_phase) begin
      seen_phase = phase;
      if (phase == PH_FULL_RATE) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (vote_q.size() == 0) begin
        $display("%0t: vote beat with nothing pending, expected none, actual %0b/%0d/%0b",
                 $time, prediction_o, sample_count_o, overflow_o);
        err_cnt++;
      end else begin
        mon_want = vote_q.pop_front();
        check_field("prediction", mon_want.pred, prediction_o);
        check_field("sample_count", mon_want.cnt, sample_count_o);
        check_field("overflow", mon_want.ovf, overflow_o);
        n_votes++;
        if (mon_want.cnt == CNT_W'(MAX_SAMPLES)) n_bound_sets++;
      end
    end
  end

  initial begin
    rise_wsum = 0;
    fall_wsum = 0;
    n_rise    = 0;
    n_fall    = 0;
    dropped   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_DIR; r++) begin
      if (dir_tbl[r].is_cfg) begin
        drain_votes();
        cfg_write(dir_tbl[r].idx, dir_tbl[r].fa);
      end else begin
        push_sample(dir_tbl[r].fa, dir_tbl[r].fb, dir_tbl[r].fc, dir_tbl[r].lbl,
                    dir_tbl[r].lst, dir_tbl[r].typed, dir_tbl[r].want);
      end
    end

    run_phase(PH_RECV_SLOW, 12, 76);
    run_phase(PH_SEND_SLOW, 76, 12);
    run_phase(PH_FULL_RATE, 0, 0);

    // fill to the bound, then past it with last on a dropped beat
    run_set(MAX_SAMPLES + 3);

    drain_votes();
    $display("checked %0d votes over %0d samples at %0d test points", n_votes, n_samples,
             n_points);
    $display("%0d sets reached the sample bound, mismatches: %0d", n_bound_sets, err_cnt);
    if (err_cnt == 0 && vote_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
